/* rtl/pag_pkg.sv */
// Shared types and register indexes for the patch angular energy gate.
`timescale 1ns / 1ps

package pag_pkg;

	typedef logic signed [15:0] comp_t;

	typedef struct packed {
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} vec3_t;

	localparam logic [2:0] REG_PW_T0_P0 = 3'd0;
	localparam logic [2:0] REG_PW_T0_P1 = 3'd1;
	localparam logic [2:0] REG_PW_T1_P0 = 3'd2;
	localparam logic [2:0] REG_PW_T1_P1 = 3'd3;
	localparam logic [2:0] REG_COUNTS   = 3'd4;

endpackage

/* rtl/pag_rotate.sv */
// Three-stage quaternion rotation of one patch director.
`timescale 1ns / 1ps

module pag_rotate #(
	parameter int FRAC_BITS = 14
) (
	input  logic            clk,
	input  logic [63:0]     quat,
	input  logic [63:0]     word,
	output pag_pkg::vec3_t  dir,
	output pag_pkg::comp_t  cosine
);

	localparam int SH = 2 * FRAC_BITS;

	function automatic logic signed [15:0] rsat(input logic signed [53:0] v);
		logic signed [53:0] r;
		logic signed [53:0] sh;
		logic signed [15:0] o;
		r = v + (54'sd1 <<< (SH - 1));
		sh = r >>> SH;
		if (sh > 54'sd32767) o = 16'sh7fff;
		else if (sh < -54'sd32768) o = 16'sh8000;
		else o = sh[15:0];
		return o;
	endfunction

	logic signed [15:0] qw, qx, qy, qz, vx, vy, vz;
	logic signed [31:0] pww, pxx, pyy, pzz, pxvx, pyvy, pzvz;
	logic signed [31:0] pyvz, pzvy, pzvx, pxvz, pxvy, pyvx;

	always_comb begin
		qw = quat[15:0];
		qx = quat[31:16];
		qy = quat[47:32];
		qz = quat[63:48];
		vx = word[15:0];
		vy = word[31:16];
		vz = word[47:32];
		pww = qw * qw;
		pxx = qx * qx;
		pyy = qy * qy;
		pzz = qz * qz;
		pxvx = qx * vx;
		pyvy = qy * vy;
		pzvz = qz * vz;
		pyvz = qy * vz;
		pzvy = qz * vy;
		pzvx = qz * vx;
		pxvz = qx * vz;
		pxvy = qx * vy;
		pyvx = qy * vx;
	end

	// stage 1: scalar part, u.v, u x v
	logic signed [34:0] s_s1;
	logic signed [33:0] d_s1;
	logic signed [32:0] cx_s1, cy_s1, cz_s1;
	logic signed [15:0] qw_s1, qx_s1, qy_s1, qz_s1, vx_s1, vy_s1, vz_s1, cos_s1;

	always_ff @(posedge clk) begin
		s_s1 <= 35'(pww) - 35'(pxx) - 35'(pyy) - 35'(pzz);
		d_s1 <= 34'(pxvx) + 34'(pyvy) + 34'(pzvz);
		cx_s1 <= 33'(pyvz) - 33'(pzvy);
		cy_s1 <= 33'(pzvx) - 33'(pxvz);
		cz_s1 <= 33'(pxvy) - 33'(pyvx);
		qw_s1 <= qw;
		qx_s1 <= qx;
		qy_s1 <= qy;
		qz_s1 <= qz;
		vx_s1 <= vx;
		vy_s1 <= vy;
		vz_s1 <= vz;
		cos_s1 <= word[63:48];
	end

	// stage 2: the nine partial products
	logic signed [50:0] ax, ay, az;
	logic signed [49:0] bx, by, bz;
	logic signed [48:0] gx, gy, gz;

	always_comb begin
		ax = s_s1 * vx_s1;
		ay = s_s1 * vy_s1;
		az = s_s1 * vz_s1;
		bx = d_s1 * qx_s1;
		by = d_s1 * qy_s1;
		bz = d_s1 * qz_s1;
		gx = qw_s1 * cx_s1;
		gy = qw_s1 * cy_s1;
		gz = qw_s1 * cz_s1;
	end

	logic signed [50:0] ax_s2, ay_s2, az_s2;
	logic signed [49:0] bx_s2, by_s2, bz_s2;
	logic signed [48:0] gx_s2, gy_s2, gz_s2;
	logic signed [15:0] cos_s2;

	always_ff @(posedge clk) begin
		ax_s2 <= ax;
		ay_s2 <= ay;
		az_s2 <= az;
		bx_s2 <= bx;
		by_s2 <= by;
		bz_s2 <= bz;
		gx_s2 <= gx;
		gy_s2 <= gy;
		gz_s2 <= gz;
		cos_s2 <= cos_s1;
	end

	// stage 3: sum, round half up, saturate
	logic signed [53:0] prex, prey, prez;

	always_comb begin
		prex = 54'(ax_s2) + (54'(bx_s2) <<< 1) + (54'(gx_s2) <<< 1);
		prey = 54'(ay_s2) + (54'(by_s2) <<< 1) + (54'(gy_s2) <<< 1);
		prez = 54'(az_s2) + (54'(bz_s2) <<< 1) + (54'(gz_s2) <<< 1);
	end

	pag_pkg::vec3_t dir_s3;
	pag_pkg::comp_t cos_s3;

	always_ff @(posedge clk) begin
		dir_s3.x <= rsat(prex);
		dir_s3.y <= rsat(prey);
		dir_s3.z <= rsat(prez);
		cos_s3 <= cos_s2;
	end

	assign dir = dir_s3;
	assign cosine = cos_s3;

endmodule

/* rtl/pag_cone.sv */
// Four-stage cone test of one rotated director against the separation.
`timescale 1ns / 1ps

module pag_cone (
	input  logic            clk,
	input  pag_pkg::vec3_t  dir,
	input  pag_pkg::vec3_t  rel,
	input  pag_pkg::comp_t  cosine,
	input  logic [31:0]     r2,
	input  logic            flip,
	output logic            hit
);

	logic signed [31:0] px, py, pz;

	always_comb begin
		px = dir.x * rel.x;
		py = dir.y * rel.y;
		pz = dir.z * rel.z;
	end

	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic signed [15:0] cos_s1;
	logic [31:0] r2_s1;

	always_ff @(posedge clk) begin
		px_s1 <= px;
		py_s1 <= py;
		pz_s1 <= pz;
		cos_s1 <= cosine;
		r2_s1 <= r2;
	end

	logic signed [33:0] dot, dotn;
	logic signed [16:0] cabs;
	logic [15:0] ac;

	always_comb begin
		dot = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);
		// second particle looks along the negated separation
		dotn = flip ? -dot : dot;
		cabs = cos_s1[15] ? -17'(cos_s1) : 17'(cos_s1);
		ac = cabs[15:0];
	end

	logic signed [33:0] dot_s2;
	logic [31:0] ac2_s2, r2_s2;
	logic cle0_s2;

	always_ff @(posedge clk) begin
		dot_s2 <= dotn;
		ac2_s2 <= ac * ac;
		r2_s2 <= r2_s1;
		cle0_s2 <= (cos_s1 <= 16'sd0);
	end

	logic signed [33:0] dabs;
	logic [32:0] ad;

	always_comb begin
		dabs = dot_s2[33] ? -dot_s2 : dot_s2;
		ad = dabs[32:0];
	end

	logic [63:0] dd_s3, cc_s3;
	logic pos_s3, nneg_s3, cle0_s3;

	always_ff @(posedge clk) begin
		dd_s3 <= 64'(ad) * 64'(ad);
		cc_s3 <= 64'(ac2_s2) * 64'(r2_s2);
		pos_s3 <= (dot_s2 > 34'sd0);
		nneg_s3 <= !dot_s2[33];
		cle0_s3 <= cle0_s2;
	end

	logic hit_s4;

	always_ff @(posedge clk) begin
		if (cle0_s3) hit_s4 <= nneg_s3 || (dd_s3 <= cc_s3);
		else hit_s4 <= pos_s3 && (dd_s3 >= cc_s3);
	end

	assign hit = hit_s4;

endmodule

/* rtl/patch_angular_energy_gate_core.sv */
// Top level of the patch angular energy gate.
//
// Use: a pair word is taken at a rising edge with start high and busy low.
// busy is always low: the pipeline takes one pair every cycle, back to back.
// Each pair gives one result word on gated_energy and patches_face, marked by
// done for exactly one cycle. The path from the accepting edge to done runs
// through eight register stages: three for the quaternion rotation, four for
// the cone test (lane products, dot sum, squaring, the wide compare), one
// output register. Every patch of both particles has its own rotation and
// cone lane, so the rate is one pair per cycle regardless of patch counts.
// Patch words and counts are written through the cfg channel, always ready;
// write them only while no pair is in flight.
// Reset clears the patch registers, the counts and all valid bits; results
// of pairs in flight at reset are dropped. The receiver cannot stall, so no
// result is ever held back.
`timescale 1ns / 1ps

module patch_angular_energy_gate_core #(
	parameter int NUM_TYPES   = 2,
	parameter int MAX_PATCHES = 2,
	parameter int FRAC_BITS   = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [47:0]        rel_pos,
	input  logic [63:0]        orient_first,
	input  logic [63:0]        orient_second,
	input  logic               first_type,
	input  logic               second_type,
	input  logic signed [31:0] iso_energy,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] gated_energy,
	output logic               patches_face
);

	localparam int NP = MAX_PATCHES * MAX_PATCHES;

	typedef struct packed {
		logic              vld;
		logic [NP-1:0]     mask;
		logic signed [31:0] energy;
	} ctl_t;

	logic [63:0] pw_q [2][2];
	logic [3:0] counts_q;

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q[0][0] <= '0;
			pw_q[0][1] <= '0;
			pw_q[1][0] <= '0;
			pw_q[1][1] <= '0;
			counts_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pag_pkg::REG_PW_T0_P0: pw_q[0][0] <= cfg_data;
				pag_pkg::REG_PW_T0_P1: pw_q[0][1] <= cfg_data;
				pag_pkg::REG_PW_T1_P0: pw_q[1][0] <= cfg_data;
				pag_pkg::REG_PW_T1_P1: pw_q[1][1] <= cfg_data;
				pag_pkg::REG_COUNTS:   counts_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// patches in use per side, then the pair mask
	logic [1:0] ni, nj, rawi, rawj;
	logic [NP-1:0] mask_c;

	always_comb begin
		rawi = counts_q[{first_type, 1'b0} +: 2];
		rawj = counts_q[{second_type, 1'b0} +: 2];
		if (int'(first_type) >= NUM_TYPES) ni = 2'd0;
		else ni = (int'(rawi) > MAX_PATCHES) ? 2'(MAX_PATCHES) : rawi;
		if (int'(second_type) >= NUM_TYPES) nj = 2'd0;
		else nj = (int'(rawj) > MAX_PATCHES) ? 2'(MAX_PATCHES) : rawj;
		for (int m = 0; m < MAX_PATCHES; m++) begin
			for (int n = 0; n < MAX_PATCHES; n++) begin
				mask_c[m * MAX_PATCHES + n] = (m < int'(ni)) && (n < int'(nj));
			end
		end
	end

	// separation path, aligned with the rotation lanes
	pag_pkg::vec3_t rel_c, rel_s1, rel_s2, rel_s3;
	logic signed [31:0] sxx, syy, szz;
	logic signed [31:0] sxx_s1, syy_s1, szz_s1;
	logic [31:0] r2_s2, r2_s3;

	always_comb begin
		rel_c.x = rel_pos[15:0];
		rel_c.y = rel_pos[31:16];
		rel_c.z = rel_pos[47:32];
		sxx = rel_c.x * rel_c.x;
		syy = rel_c.y * rel_c.y;
		szz = rel_c.z * rel_c.z;
	end

	always_ff @(posedge clk) begin
		rel_s1 <= rel_c;
		rel_s2 <= rel_s1;
		rel_s3 <= rel_s2;
		sxx_s1 <= sxx;
		syy_s1 <= syy;
		szz_s1 <= szz;
		r2_s2 <= sxx_s1 + syy_s1 + szz_s1;
		r2_s3 <= r2_s2;
	end

	ctl_t ctl_c, ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;

	always_comb begin
		ctl_c.vld = start && !busy;
		ctl_c.mask = mask_c;
		ctl_c.energy = iso_energy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			ctl_s1 <= ctl_c;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4.vld <= ctl_s3.vld;
			ctl_s4.energy <= ctl_s3.energy;
			// zero separation never faces
			ctl_s4.mask <= ctl_s3.mask & {NP{r2_s3 != 32'd0}};
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	logic [MAX_PATCHES-1:0] hit_first, hit_second;

	for (genvar g = 0; g < MAX_PATCHES; g++) begin : g_lane
		pag_pkg::vec3_t dir_f, dir_s;
		pag_pkg::comp_t cos_f, cos_s;

		pag_rotate #(.FRAC_BITS(FRAC_BITS)) u_rot_f (
			.clk    (clk),
			.quat   (orient_first),
			.word   (pw_q[first_type][g]),
			.dir    (dir_f),
			.cosine (cos_f)
		);

		pag_rotate #(.FRAC_BITS(FRAC_BITS)) u_rot_s (
			.clk    (clk),
			.quat   (orient_second),
			.word   (pw_q[second_type][g]),
			.dir    (dir_s),
			.cosine (cos_s)
		);

		pag_cone u_cone_f (
			.clk    (clk),
			.dir    (dir_f),
			.rel    (rel_s3),
			.cosine (cos_f),
			.r2     (r2_s3),
			.flip   (1'b0),
			.hit    (hit_first[g])
		);

		pag_cone u_cone_s (
			.clk    (clk),
			.dir    (dir_s),
			.rel    (rel_s3),
			.cosine (cos_s),
			.r2     (r2_s3),
			.flip   (1'b1),
			.hit    (hit_second[g])
		);
	end

	logic [NP-1:0] pair_hit;

	always_comb begin
		for (int m = 0; m < MAX_PATCHES; m++) begin
			for (int n = 0; n < MAX_PATCHES; n++) begin
				pair_hit[m * MAX_PATCHES + n] = hit_first[m] && hit_second[n];
			end
		end
	end

	logic done_s8, face_s8;
	logic signed [31:0] energy_s8;
	logic face_c;

	assign face_c = |(pair_hit & ctl_s7.mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s8 <= 1'b0;
			face_s8 <= 1'b0;
			energy_s8 <= '0;
		end else begin
			done_s8 <= ctl_s7.vld;
			face_s8 <= face_c;
			energy_s8 <= face_c ? ctl_s7.energy : 32'sd0;
		end
	end

	assign done = done_s8;
	assign patches_face = face_s8;
	assign gated_energy = energy_s8;

endmodule

/* tb/sv/patch_angular_energy_gate_checker.sv */
// Checker for the patch angular energy gate: tracks config, predicts and compares results.
`timescale 1ns / 1ps

module patch_angular_energy_gate_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [47:0]        rel_pos,
	input  logic [63:0]        orient_first,
	input  logic [63:0]        orient_second,
	input  logic               first_type,
	input  logic               second_type,
	input  logic signed [31:0] iso_energy,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               done,
	input  logic signed [31:0] gated_energy,
	input  logic               patches_face,
	output int                 errors,
	output int                 pending,
	output int                 faces_seen
);

	localparam int FRAC = 14;

	typedef struct {
		logic signed [31:0] energy;
		logic               face;
	} gate_word_t;

	logic [63:0] patch_word [2][2];
	logic [3:0]  patch_cnt;
	gate_word_t  gate_q [$];

	assign pending = gate_q.size();

	function automatic longint comp(logic [63:0] w, int pos);
		return longint'($signed(w[pos +: 16]));
	endfunction

	function automatic longint round_sat(longint x);
		longint v;
		v = (x + (longint'(1) << (2 * FRAC - 1))) >>> (2 * FRAC);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	// director rotated by q, dotted with r
	function automatic longint rotated_dot(logic [63:0] q, logic [63:0] pw,
			longint rx, longint ry, longint rz);
		longint w, x, y, z, vx, vy, vz, s, d, cx, cy, cz, ex, ey, ez;
		w = comp(q, 0); x = comp(q, 16); y = comp(q, 32); z = comp(q, 48);
		vx = comp(pw, 0); vy = comp(pw, 16); vz = comp(pw, 32);
		s = w * w - (x * x + y * y + z * z);
		d = x * vx + y * vy + z * vz;
		cx = y * vz - z * vy;
		cy = z * vx - x * vz;
		cz = x * vy - y * vx;
		ex = round_sat(s * vx + 2 * d * x + 2 * w * cx);
		ey = round_sat(s * vy + 2 * d * y + 2 * w * cy);
		ez = round_sat(s * vz + 2 * d * z + 2 * w * cz);
		return ex * rx + ey * ry + ez * rz;
	endfunction

	function automatic bit in_cone(longint dot, longint c, longint unsigned r2);
		longint unsigned ad, ac, dd, cc;
		ad = (dot < 0) ? -dot : dot;
		ac = (c < 0) ? -c : c;
		dd = ad * ad;
		cc = ac * ac * r2;
		if (c <= 0) return (dot >= 0) || (dd <= cc);
		return (dot > 0) && (dd >= cc);
	endfunction

	function automatic int used_patches(logic t);
		int n;
		n = t ? patch_cnt[3:2] : patch_cnt[1:0];
		return (n > 2) ? 2 : n;
	endfunction

	function automatic bit pair_faces(logic [47:0] r, logic [63:0] qa, logic [63:0] qb,
			logic ta, logic tb);
		longint rx, ry, rz;
		longint unsigned r2;
		rx = comp(r, 0); ry = comp(r, 16); rz = comp(r, 32);
		r2 = rx * rx + ry * ry + rz * rz;
		if (r2 == 0) return 0;
		for (int m = 0; m < used_patches(ta); m++) begin
			if (!in_cone(rotated_dot(qa, patch_word[ta][m], rx, ry, rz),
					comp(patch_word[ta][m], 48), r2))
				continue;
			for (int n = 0; n < used_patches(tb); n++)
				if (in_cone(-rotated_dot(qb, patch_word[tb][n], rx, ry, rz),
						comp(patch_word[tb][n], 48), r2))
					return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gate_word_t exp_w;
		bit f;
		if (!arst_n) begin
			for (int t = 0; t < 2; t++)
				for (int p = 0; p < 2; p++)
					patch_word[t][p] = '0;
			patch_cnt = '0;
			gate_q.delete();
			errors = 0;
			faces_seen = 0;
		end else begin
			if (done) begin
				if (gate_q.size() == 0) begin
					$error("result word with no expectation pending");
					errors++;
				end else begin
					exp_w = gate_q.pop_front();
					if (gated_energy !== exp_w.energy) begin
						$error("gated_energy: expected %0d, got %0d", exp_w.energy,
							gated_energy);
						errors++;
					end
					if (patches_face !== exp_w.face) begin
						$error("patches_face: expected %0b, got %0b", exp_w.face,
							patches_face);
						errors++;
					end
					if (exp_w.face) faces_seen++;
				end
			end
			if (start && !busy) begin
				f = pair_faces(rel_pos, orient_first, orient_second, first_type,
					second_type);
				exp_w.face = f;
				exp_w.energy = f ? iso_energy : 32'sd0;
				gate_q.push_back(exp_w);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pag_pkg::REG_PW_T0_P0: patch_word[0][0] = cfg_data;
					pag_pkg::REG_PW_T0_P1: patch_word[0][1] = cfg_data;
					pag_pkg::REG_PW_T1_P0: patch_word[1][0] = cfg_data;
					pag_pkg::REG_PW_T1_P1: patch_word[1][1] = cfg_data;
					pag_pkg::REG_COUNTS:   patch_cnt = cfg_data[3:0];
					default: ;
				endcase
			end
		end
	end

endmodule

/* tb/sv/patch_angular_energy_gate_core_test.sv */
// Top of the patch angular energy gate testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module patch_angular_energy_gate_core_test;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 16;
	localparam logic [15:0] ONE   = 16'sd16384;
	localparam logic [15:0] HALF2 = 16'sd11585;  // cos 45 deg

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [47:0]        rel_pos = '0;
	logic [63:0]        orient_first = '0;
	logic [63:0]        orient_second = '0;
	logic               first_type = 1'b0;
	logic               second_type = 1'b0;
	logic signed [31:0] iso_energy = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [63:0]        cfg_data = '0;
	logic               done;
	logic signed [31:0] gated_energy;
	logic               patches_face;

	int errors, pending, faces_seen;
	int items_sent = 0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	patch_angular_energy_gate_core dut (.*);
	patch_angular_energy_gate_checker chk (.*);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// write stays asserted across back-to-back writes; cfg_end drops it
	task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic cfg_end();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pair(logic [47:0] r, logic [63:0] qa, logic [63:0] qb,
			logic ta, logic tb, logic [31:0] e);
		int g;
		g = gap_len();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
		start <= 1'b1;
		rel_pos <= r;
		orient_first <= qa;
		orient_second <= qb;
		first_type <= ta;
		second_type <= tb;
		iso_energy <= e;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] neg(logic [15:0] v);
		return -v;
	endfunction

	// axis-aligned and quarter-turn unit quaternions, packed {z,y,x,w}
	function automatic logic [63:0] unit_quat();
		logic [15:0] s;
		s = $urandom_range(0, 1) ? ONE : neg(ONE);
		case ($urandom_range(0, 6))
			0: return {16'd0, 16'd0, 16'd0, s};
			1: return {16'd0, 16'd0, s, 16'd0};
			2: return {16'd0, s, 16'd0, 16'd0};
			3: return {s, 16'd0, 16'd0, 16'd0};
			4: return {16'd0, 16'd0, HALF2, HALF2};
			5: return {16'd0, HALF2, 16'd0, neg(HALF2)};
			default: return {HALF2, 16'd0, 16'd0, HALF2};
		endcase
	endfunction

	function automatic logic [47:0] axis_sep();
		logic [15:0] c [3];
		int a;
		a = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++)
			c[i] = 16'($signed($urandom_range(0, 6)) - 3);
		c[a] = $urandom_range(0, 1) ? 16'($urandom_range(1, 32767))
			: neg(16'($urandom_range(1, 32767)));
		return {c[2], c[1], c[0]};
	endfunction

	function automatic logic [63:0] director(int axis, bit negative, logic [15:0] cosv);
		logic [15:0] v [3];
		v = '{16'd0, 16'd0, 16'd0};
		v[axis] = negative ? neg(ONE) : ONE;
		return {cosv, v[2], v[1], v[0]};
	endfunction

	task automatic random_pairs(int count);
		repeat (count) begin
			if ($urandom_range(0, 9) < 7)
				send_pair(axis_sep(), unit_quat(), unit_quat(), 1'($urandom),
					1'($urandom), $urandom);
			else
				send_pair(48'({$urandom, $urandom}), {$urandom, $urandom},
					{$urandom, $urandom}, 1'($urandom), 1'($urandom), $urandom);
		end
	endtask

	task automatic cone_cos(output logic [15:0] c);
		case ($urandom_range(0, 3))
			0: c = 16'd0;
			1: c = HALF2;
			2: c = neg(HALF2);
			default: c = 16'($urandom_range(0, 16384));
		endcase
	endtask

	initial begin
		logic [15:0] c0, c1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: no patches, nothing faces
		send_pair('0, '0, '0, 1'b0, 1'b0, 32'h7FFF_FFFF);
		send_pair(48'h7FFF_8000_7FFF, {4{16'h8000}}, {4{16'h7FFF}}, 1'b1, 1'b1,
			32'h8000_0000);
		send_pair(axis_sep(), unit_quat(), unit_quat(), 1'b0, 1'b1, 32'd1);
		drain();

		// well-formed patches, counts field at max (saturates to two each)
		cone_cos(c0); cone_cos(c1);
		cfg_write(pag_pkg::REG_PW_T0_P0, director(0, 0, c0));
		cfg_write(pag_pkg::REG_PW_T0_P1, director(2, 1, c1));
		cfg_write(pag_pkg::REG_PW_T1_P0, director(0, 1, c0));
		cfg_write(pag_pkg::REG_PW_T1_P1, director(1, 0, c1));
		cfg_write(pag_pkg::REG_COUNTS, 64'hF);
		// indexes past the counts register must be ignored
		cfg_write(3'd5, '1);
		cfg_write(3'd6, '1);
		cfg_write(3'd7, '1);
		cfg_end();
		// +x separation, identity both: face head-on
		send_pair({16'd0, 16'd0, 16'd1000}, {48'd0, ONE}, {48'd0, ONE}, 1'b0, 1'b1,
			32'sd12345);
		send_pair({16'd0, 16'd0, 16'd1000}, {48'd0, ONE}, {48'd0, ONE}, 1'b0, 1'b1,
			32'h8000_0000);
		send_pair({16'd0, 16'd0, 16'd1000}, {48'd0, ONE}, {48'd0, ONE}, 1'b0, 1'b1,
			32'h7FFF_FFFF);
		send_pair('0, {48'd0, ONE}, {48'd0, ONE}, 1'b0, 1'b1, 32'd5);
		send_pair({16'd0, 16'd0, 16'h8000}, {48'd0, ONE}, {48'd0, ONE}, 1'b1, 1'b0,
			32'sd77);
		send_pair({16'h7FFF, 16'h7FFF, 16'h7FFF}, {4{16'h8000}}, {4{16'h8000}}, 1'b1,
			1'b1, 32'sd9);
		send_pair({16'h8000, 16'h8000, 16'h8000}, {4{16'h7FFF}}, {4{16'h7FFF}}, 1'b0,
			1'b0, -32'sd9);
		random_pairs(12);
		random_pairs(230);
		drain();

		// cosine extremes, mixed counts
		cfg_write(pag_pkg::REG_PW_T0_P0, director(0, 0, 16'h8000));
		cfg_write(pag_pkg::REG_PW_T0_P1, director(1, 1, 16'h7FFF));
		cfg_write(pag_pkg::REG_PW_T1_P0, director(0, 1, 16'd0));
		cfg_write(pag_pkg::REG_PW_T1_P1, director(2, 0, 16'h8000));
		cfg_write(pag_pkg::REG_COUNTS, 64'b0110);
		cfg_end();
		random_pairs(200);
		drain();

		// single patch on type 0, none on type 1
		cfg_write(pag_pkg::REG_COUNTS, 64'b0001);
		cfg_end();
		random_pairs(40);
		drain();

		// raw random patch words and counts
		repeat (4) begin
			cfg_write(pag_pkg::REG_PW_T0_P0, {$urandom, $urandom});
			cfg_write(pag_pkg::REG_PW_T0_P1, {$urandom, $urandom});
			cfg_write(pag_pkg::REG_PW_T1_P0, {$urandom, $urandom});
			cfg_write(pag_pkg::REG_PW_T1_P1, {$urandom, $urandom});
			cfg_write(pag_pkg::REG_COUNTS, 64'($urandom_range(0, 15)));
			cfg_end();
			random_pairs(50);
			drain();
		end

		$display("Run covered %0d pairs over eight patch setups; %0d facing results seen.",
			items_sent, faces_seen);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
